>>> sv/b64sd_pkg.sv
// Constants and the symbol map for the strict base64 decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_PAD = 2'd2;
    localparam logic [1:0] ST_BAD_SYM = 2'd3;

    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 16;

    typedef struct packed {
        logic       invalid;
        logic [5:0] value;
    } sym_t;

    // Map one character to its six-bit value; flag anything outside the alphabet.
    function automatic sym_t sym_decode(input logic [7:0] c);
        sym_t r;
        r.invalid = 1'b0;
        r.value   = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            r.value = 6'd62;
        end
        else if (c == 8'h2F) begin
            r.value = 6'd63;
        end
        else begin
            r.invalid = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/base64_strict_decoder_top.sv
// Strict base64 decoder: one character in, decoded bytes and an end status out.
// A character is taken into the input register, then decoded into the result
// register once that register is free; its first result then shows on the output.
// One character per cycle while each gives at most one result and m_axis_tready is
// high; a group-completing character holds the input until its up to 4 results leave.
// Reset clears the group state, error code and both stages' flags; not the payload.
`timescale 1ns / 1ps
`default_nettype none

module base64_strict_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  wire logic        s_axis_tlast,   // is_final
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] status, rest zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // is_last
);
    import b64sd_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_sym_reg;
    logic       in_fin_reg;

    // decoder state
    logic [1:0]  pos_reg, pos_next;
    logic [17:0] gb_reg, gb_next;
    logic [1:0]  pc_reg, pc_next;
    logic [1:0]  fe_reg, fe_next;

    // result register: up to three bytes and an optional status
    logic       bun_valid_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic [1:0] nb_reg;
    logic       bfin_reg;
    logic [1:0] bst_reg;
    logic [1:0] idx_reg;

    logic [2:0]  total;
    logic        last_res;
    logic        out_take;
    logic        bun_free;
    logic        in_moves;
    logic        is_status;
    logic [7:0]  cur_byte;

    sym_t        sv;
    logic        is_pad;
    logic [1:0]  err;
    logic [1:0]  pc_new;
    logic [5:0]  v;
    logic [23:0] g;
    logic [1:0]  nb_next;
    logic [1:0]  st_next;

    assign total     = {1'b0, nb_reg} + {2'b00, bfin_reg};
    assign last_res  = ({1'b0, idx_reg} + 3'd1) == total;
    assign out_take  = bun_valid_reg && m_axis_tready;
    assign bun_free  = !bun_valid_reg || (out_take && last_res);
    assign in_moves  = in_valid_reg && bun_free;
    assign s_axis_tready = !in_valid_reg || bun_free;

    always_comb
    begin
        sv      = sym_decode(in_sym_reg);
        is_pad  = (in_sym_reg == PAD_CHAR);
        err     = ST_OK;
        pc_new  = pc_reg;
        v       = 6'd0;
        nb_next = 2'd0;
        pos_next = pos_reg;
        gb_next  = gb_reg;
        pc_next  = pc_reg;
        fe_next  = fe_reg;
        g        = {gb_reg, 6'd0};
        st_next  = ST_OK;
        if (in_moves)
        begin
            if (fe_reg == ST_OK)
            begin
                if (is_pad)
                begin
                    if (pos_reg < 2'd2 || (pos_reg == 2'd3 && !in_fin_reg))
                    begin
                        err = ST_BAD_PAD;
                    end
                    else
                    begin
                        pc_new = pc_reg + 2'd1;
                    end
                end
                else if (pc_reg != 2'd0)
                begin
                    err = ST_BAD_PAD;
                end
                else
                begin
                    v = sv.value;
                    if (sv.invalid)
                    begin
                        err = ST_BAD_SYM;
                    end
                end
                // padding inside a group that is not the last one
                if (err == ST_OK && pos_reg == 2'd3 && pc_new != 2'd0 && !in_fin_reg)
                begin
                    err = ST_BAD_PAD;
                end
                pc_next = pc_new;
                g = {gb_reg, v};
                if (err != ST_OK)
                begin
                    fe_next = err;
                end
                else if (pos_reg != 2'd3)
                begin
                    gb_next = {gb_reg[11:0], v};
                end
                else
                begin
                    case (pc_new)
                        2'd0:    nb_next = 2'd3;
                        2'd1:    nb_next = 2'd2;
                        default: nb_next = 2'd1;
                    endcase
                end
            end
            if (pos_reg == 2'd3)
            begin
                gb_next = 18'd0;
                pc_next = 2'd0;
            end
            pos_next = pos_reg + 2'd1;
            st_next  = (pos_reg != 2'd3) ? ST_BAD_LEN : fe_next;
            if (in_fin_reg)
            begin
                // end of string: back to idle
                pos_next = 2'd0;
                gb_next  = 18'd0;
                pc_next  = 2'd0;
                fe_next  = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_sym_reg    <= 8'd0;
            in_fin_reg    <= 1'b0;
            pos_reg       <= 2'd0;
            gb_reg        <= 18'd0;
            pc_reg        <= 2'd0;
            fe_reg        <= ST_OK;
            bun_valid_reg <= 1'b0;
            nb_reg        <= 2'd0;
            bfin_reg      <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
                in_sym_reg   <= s_axis_tdata;
                in_fin_reg   <= s_axis_tlast;
            end
            else if (in_moves)
            begin
                in_valid_reg <= 1'b0;
            end
            pos_reg <= pos_next;
            gb_reg  <= gb_next;
            pc_reg  <= pc_next;
            fe_reg  <= fe_next;
            if (in_moves)
            begin
                // skip items that give no result
                bun_valid_reg <= (nb_next != 2'd0) || in_fin_reg;
                nb_reg        <= nb_next;
                bfin_reg      <= in_fin_reg;
                idx_reg       <= 2'd0;
            end
            else if (bun_free)
            begin
                bun_valid_reg <= 1'b0;
            end
            else if (out_take)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_moves)
        begin
            b0_reg  <= g[23:16];
            b1_reg  <= g[15:8];
            b2_reg  <= g[7:0];
            bst_reg <= st_next;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = b0_reg;
            2'd1:    cur_byte = b1_reg;
            default: cur_byte = b2_reg;
        endcase
    end

    assign is_status     = (idx_reg == nb_reg);
    assign m_axis_tvalid = bun_valid_reg;
    assign m_axis_tuser  = is_status;
    assign m_axis_tlast  = is_status;
    assign m_axis_tdata  = {6'd0, (is_status ? bst_reg : ST_OK),
                            (is_status ? 8'd0 : cur_byte)};

    // a held result set always has a result at the current index
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bun_valid_reg |-> ({1'b0, idx_reg} < total))
        else $error("result index beyond result count");

    // a final character leaves the decoder idle
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_moves && in_fin_reg) |=> (pos_reg == 2'd0 && fe_reg == ST_OK && pc_reg == 2'd0))
        else $error("decoder state not cleared after final character");

    // no data bytes once an error is recorded
    a_no_bytes_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_moves && fe_reg != ST_OK) |-> (nb_next == 2'd0))
        else $error("bytes produced after an error");

    // the input register never drops a request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !bun_free) |=> (in_valid_reg && $stable(in_sym_reg)))
        else $error("pending character lost");

endmodule

`default_nettype wire
